[rtl/ape_pkg.sv]
// shared types, codes and color helpers for the playfield pixel expander
package ape_pkg;

  localparam int unsigned PfColorsW = 40;
  localparam int unsigned PmColorsW = 32;
  localparam int unsigned CfgIndexW = 8;

  // register indexes on the configuration port
  localparam logic [CfgIndexW-1:0] CFG_PLAYFIELD_COLORS = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_PLAYER_COLORS    = 8'd1;
  localparam logic [CfgIndexW-1:0] CFG_CHAR_CONTROL     = 8'd2;
  localparam logic [CfgIndexW-1:0] CFG_GTIA_MODE        = 8'd3;

  // display mode numbers
  localparam logic [3:0] MODE_CHR40      = 4'd2;
  localparam logic [3:0] MODE_CHR40_DESC = 4'd3;
  localparam logic [3:0] MODE_CHR4C      = 4'd4;
  localparam logic [3:0] MODE_CHR4C_TALL = 4'd5;
  localparam logic [3:0] MODE_CHR20      = 4'd6;
  localparam logic [3:0] MODE_CHR20_TALL = 4'd7;
  localparam logic [3:0] MODE_MAP_A      = 4'd8;
  localparam logic [3:0] MODE_MAP_B      = 4'd9;
  localparam logic [3:0] MODE_MAP_C      = 4'd10;
  localparam logic [3:0] MODE_MAP_D      = 4'd11;
  localparam logic [3:0] MODE_MAP_E      = 4'd12;
  localparam logic [3:0] MODE_MAP_F      = 4'd13;
  localparam logic [3:0] MODE_MAP_G      = 4'd14;
  localparam logic [3:0] MODE_MAP_HI     = 4'd15;

  // priority mode codes for the high-color mode
  localparam logic [1:0] GTIA_HIRES = 2'd0;
  localparam logic [1:0] GTIA_LUM   = 2'd1;
  localparam logic [1:0] GTIA_IDX   = 2'd2;
  localparam logic [1:0] GTIA_HUE   = 2'd3;

  localparam logic [7:0] HUE_MASK  = 8'hf0;
  localparam logic [7:0] LUM_MASK  = 8'h0e;
  localparam logic [7:0] CHAR_INV  = 8'h80;

  typedef enum logic [3:0] {
    FMT_NONE,
    FMT_HIRES,
    FMT_1BPP_GLYPH,
    FMT_1BPP_MAP,
    FMT_2BPP_GLYPH,
    FMT_2BPP_MAP,
    FMT_GTIA_LUM,
    FMT_GTIA_IDX,
    FMT_GTIA_HUE
  } pix_fmt_t;

  typedef struct packed {
    logic [3:0] display_mode;
    logic [7:0] char_byte;
    logic [7:0] glyph_byte;
    logic [3:0] scan_row;
  } in_item_t;

  typedef struct packed {
    logic [63:0] pixels;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [PfColorsW-1:0] playfield_colors;
    logic [PmColorsW-1:0] player_colors;
    logic [1:0]           char_control;
    logic [1:0]           gtia_mode;
  } cfg_t;

  // decoded byte held in the input stage
  typedef struct packed {
    pix_fmt_t   fmt;
    logic [7:0] data;
    logic [1:0] sel;
    logic [1:0] rep_sh;
    logic [1:0] last_idx;
  } stage_t;

  function automatic logic [7:0] pf_color(input logic [PfColorsW-1:0] pf, input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = pf[7:0];
      3'd1:    c = pf[15:8];
      3'd2:    c = pf[23:16];
      3'd3:    c = pf[31:24];
      3'd4:    c = pf[39:32];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pm_color(input logic [PmColorsW-1:0] pm, input logic [1:0] i);
    return pm[{i, 3'b000} +: 8];
  endfunction

endpackage

[rtl/antic_playfield_pixel_expander_top.sv]
// playfield pixel expander top level: input stage, group counter and result register
//
// Each accepted byte is decoded into an input stage register; from there one 8-pixel
// group per cycle moves into the single result register while it is free, so a byte
// gives 1, 2 or 4 groups (modes 2-5, 13-15: 1; modes 6, 7, 10-12: 2; modes 8, 9: 4).
// Single-group bytes stream at one per cycle while the output is not stalled. The
// first group passes the input stage register, then the result register. Modes 0
// and 1 are accepted and produce nothing. Configuration writes are always accepted
// (cfg_ready is always high) and must only happen while no transaction is in flight.
module antic_playfield_pixel_expander_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ape_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ape_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ape_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [ape_pkg::PfColorsW-1:0] cfg_data
);
  import ape_pkg::*;

  cfg_t       cfg;
  stage_t     dec;
  stage_t     stage_r;
  logic       stage_valid_r;
  logic [1:0] grp_r;
  logic       out_valid_r;
  out_item_t  out_r;
  logic [63:0] pixels;
  logic       in_fire, out_free, emit, done, is_last;

  ape_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ape_decode u_dec (
    .item  (in_data),
    .cfg   (cfg),
    .stage (dec)
  );

  ape_pixel_gen u_gen (
    .stage  (stage_r),
    .grp    (grp_r),
    .cfg    (cfg),
    .pixels (pixels)
  );

  assign out_free = !out_valid_r || out_ready;
  assign is_last  = (grp_r == stage_r.last_idx);
  assign emit     = stage_valid_r && (stage_r.fmt != FMT_NONE) && out_free;
  assign done     = stage_valid_r && ((stage_r.fmt == FMT_NONE) || (out_free && is_last));
  assign in_ready = !stage_valid_r || done;
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      grp_r         <= 2'd0;
    end else if (in_fire) begin
      stage_valid_r <= 1'b1;
      grp_r         <= 2'd0;
    end else if (done) begin
      stage_valid_r <= 1'b0;
    end else if (emit) begin
      grp_r <= grp_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_r <= dec;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.pixels <= pixels;
      out_r.last   <= is_last;
    end
  end

endmodule

[rtl/ape_cfg_regs.sv]
// configuration register file written over the cfg channel
module ape_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ape_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [ape_pkg::PfColorsW-1:0] cfg_data,
  output ape_pkg::cfg_t                 cfg
);
  import ape_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PLAYFIELD_COLORS: cfg_nxt.playfield_colors = cfg_data;
        CFG_PLAYER_COLORS:    cfg_nxt.player_colors    = cfg_data[PmColorsW-1:0];
        CFG_CHAR_CONTROL:     cfg_nxt.char_control     = cfg_data[1:0];
        CFG_GTIA_MODE:        cfg_nxt.gtia_mode        = cfg_data[1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/ape_decode.sv]
// mode decode and character blank, invert and descender masking
module ape_decode (
  input  ape_pkg::in_item_t item,
  input  ape_pkg::cfg_t     cfg,
  output ape_pkg::stage_t   stage
);
  import ape_pkg::*;

  logic [3:0] row_adj;
  logic       show;
  logic [7:0] glyph_m;
  logic [7:0] glyph_c;

  // mode 3 descender rows
  assign row_adj = item.scan_row - 4'd2;

  always_comb begin
    if (item.display_mode == MODE_CHR40_DESC) begin
      show = (item.char_byte[6:5] == 2'b11) ? !row_adj[3] : !item.scan_row[3];
    end else begin
      show = 1'b1;
    end
    glyph_m = show ? item.glyph_byte : 8'h00;
    glyph_c = glyph_m;
    if ((item.char_byte & CHAR_INV) != 8'h00) begin
      if (cfg.char_control[0]) begin
        glyph_c = 8'h00;
      end
      if (cfg.char_control[1]) begin
        glyph_c = ~glyph_c;
      end
    end
  end

  always_comb begin
    stage          = '0;
    stage.fmt      = FMT_NONE;
    stage.sel      = item.char_byte[7:6];
    stage.data     = item.char_byte;
    unique case (item.display_mode) inside
      MODE_CHR40, MODE_CHR40_DESC: begin
        stage.fmt  = FMT_HIRES;
        stage.data = glyph_c;
      end
      MODE_CHR4C, MODE_CHR4C_TALL: begin
        stage.fmt    = FMT_2BPP_GLYPH;
        stage.data   = item.glyph_byte;
        stage.rep_sh = 2'd1;
      end
      MODE_CHR20, MODE_CHR20_TALL: begin
        stage.fmt      = FMT_1BPP_GLYPH;
        stage.data     = item.glyph_byte;
        stage.rep_sh   = 2'd1;
        stage.last_idx = 2'd1;
      end
      MODE_MAP_A: begin
        stage.fmt      = FMT_2BPP_MAP;
        stage.rep_sh   = 2'd3;
        stage.last_idx = 2'd3;
      end
      MODE_MAP_B: begin
        stage.fmt      = FMT_1BPP_MAP;
        stage.rep_sh   = 2'd2;
        stage.last_idx = 2'd3;
      end
      MODE_MAP_C: begin
        stage.fmt      = FMT_2BPP_MAP;
        stage.rep_sh   = 2'd2;
        stage.last_idx = 2'd1;
      end
      MODE_MAP_D, MODE_MAP_E: begin
        stage.fmt      = FMT_1BPP_MAP;
        stage.rep_sh   = 2'd1;
        stage.last_idx = 2'd1;
      end
      MODE_MAP_F, MODE_MAP_G: begin
        stage.fmt    = FMT_2BPP_MAP;
        stage.rep_sh = 2'd1;
      end
      MODE_MAP_HI: begin
        stage.rep_sh = 2'd2;
        unique case (cfg.gtia_mode)
          GTIA_HIRES: begin
            stage.fmt    = FMT_HIRES;
            stage.rep_sh = 2'd0;
          end
          GTIA_LUM: stage.fmt = FMT_GTIA_LUM;
          GTIA_IDX: stage.fmt = FMT_GTIA_IDX;
          GTIA_HUE: stage.fmt = FMT_GTIA_HUE;
          default:  stage.fmt = FMT_NONE;
        endcase
      end
      default: stage.fmt = FMT_NONE;
    endcase
  end

endmodule

[rtl/ape_pixel_gen.sv]
// builds one group of eight color indexes from the decoded byte
module ape_pixel_gen (
  input  ape_pkg::stage_t stage,
  input  logic [1:0]      grp,
  input  ape_pkg::cfg_t   cfg,
  output logic [63:0]     pixels
);
  import ape_pkg::*;

  logic [7:0] bg, pf0, pf2, pf3, hifore;

  assign bg     = pf_color(cfg.playfield_colors, 3'd0);
  assign pf0    = pf_color(cfg.playfield_colors, 3'd1);
  assign pf2    = pf_color(cfg.playfield_colors, 3'd3);
  assign pf3    = pf_color(cfg.playfield_colors, 3'd4);
  assign hifore = (pf2 & HUE_MASK) | (pf_color(cfg.playfield_colors, 3'd2) & LUM_MASK);

  always_comb begin
    logic [4:0] pos;
    logic [4:0] idx;
    logic       bit_v;
    logic [1:0] pair;
    logic [1:0] v2;
    logic [3:0] nib;
    logic [7:0] color;
    pixels = '0;
    for (int j = 0; j < 8; j++) begin
      pos   = {grp, 3'(j)};
      idx   = pos >> stage.rep_sh;
      bit_v = stage.data[~idx[2:0]];
      pair  = idx[1:0];
      v2    = {stage.data[{~pair, 1'b1}], stage.data[{~pair, 1'b0}]};
      nib   = idx[0] ? stage.data[3:0] : stage.data[7:4];
      case (stage.fmt)
        FMT_HIRES:      color = bit_v ? hifore : pf2;
        FMT_1BPP_GLYPH: color = bit_v ? pf_color(cfg.playfield_colors, {1'b0, stage.sel} + 3'd1)
                                      : bg;
        FMT_1BPP_MAP:   color = bit_v ? pf0 : bg;
        FMT_2BPP_GLYPH: begin
          if (v2 == 2'd3) begin
            color = stage.sel[1] ? pf3 : pf2;
          end else begin
            color = pf_color(cfg.playfield_colors, {1'b0, v2});
          end
        end
        FMT_2BPP_MAP:   color = pf_color(cfg.playfield_colors, {1'b0, v2});
        FMT_GTIA_LUM:   color = {bg[7:4], nib};
        FMT_GTIA_IDX: begin
          case (nib[3:2])
            2'd0:    color = pm_color(cfg.player_colors, nib[1:0]);
            2'd2:    color = bg;
            default: color = pf_color(cfg.playfield_colors, {1'b0, nib[1:0]} + 3'd1);
          endcase
        end
        FMT_GTIA_HUE:   color = (nib == 4'd0) ? 8'h00 : {nib, bg[3:0]};
        default:        color = 8'h00;
      endcase
      pixels[8*(7-j) +: 8] = color;
    end
  end

endmodule

[rtl/ape_checker.sv]
// port-level checks for the playfield pixel expander, bound to the top level
module ape_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ape_pkg::out_item_t out_data
);
  import ape_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // groups of one byte come back to back once the previous one is taken
  a_group_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside the groups of one byte");

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind antic_playfield_pixel_expander_top ape_checker u_ape_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
